### rtl/psn_pkg.sv
// ----------------------------------------------------------------------------
// psn_pkg: shared definitions for the primitive surface normal block
// Default widths, tolerance register layout and primitive kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package psn_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int TOL_WIDTH = 16;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd7;

  localparam int KIND_WIDTH = 2;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_SPHERE      = 2'd0,
    KIND_PLANE       = 2'd1,
    KIND_CYLINDER    = 2'd2,
    KIND_UNSUPPORTED = 2'd3
  } kind_e;

endpackage

`default_nettype wire

### rtl/primitive_surface_normal.sv
// ----------------------------------------------------------------------------
// primitive_surface_normal
// Surface normal of a sphere, plane or cylinder at a hit point, Q16.16 default.
// ----------------------------------------------------------------------------
// One word is accepted every clock and one result word leaves per input word.
// The pipeline holds nine stages of differences, products, cap tests, radial
// part and squared length, then a square root pipeline retiring one root bit
// per stage, then three parallel divider pipelines retiring one quotient bit
// per stage, then the output register. A stall on the master side holds the
// whole pipeline.
// tolerance is read live; write it only while the pipeline is empty.
`default_nettype none

module primitive_surface_normal #(
  parameter int COORD_WIDTH = psn_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = psn_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [psn_pkg::TOL_WIDTH-1:0]             cfg_wdata_i,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // hit_x, hit_y, hit_z, center_x, center_y, center_z, axis_x, axis_y, axis_z,
  // radius, height
  input  logic [((11*COORD_WIDTH-2+7)/8)*8-1:0]     s_axis_tdata,
  // shape_kind
  input  logic [psn_pkg::KIND_WIDTH-1:0]            s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // valid_res
  output logic [0:0]                                m_axis_tuser
);

  import psn_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int CW  = W + 1;
  localparam int VW  = W + 2;
  localparam int PW  = 2 * W + 2;
  localparam int DW  = 2 * W + 3;
  localparam int XW  = DW + TOL_WIDTH + F;
  localparam int PRW = 2 * W + 2 - F;
  localparam int RW  = CW + PRW;
  localparam int N   = W + 1;
  localparam int RMW = N + 3;
  localparam int D   = F + 1;
  localparam int OW  = W + F + 3;
  localparam int OUT_DW = ((3 * W + 7) / 8) * 8;

  localparam logic signed [W-1:0]   CMAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]   CMINW = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+2:0]   TMAX  = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0]   TMIN  = {4'b1111, {(W-1){1'b0}}};
  localparam logic [2*W-2:0]        OFF_LIM = {{(W-2){1'b0}}, 1'b1, {W{1'b0}}};
  localparam logic [DW-1:0]         DOT_LIM = {{(W+2){1'b0}}, 1'b1, {W{1'b0}}};
  localparam logic signed [RW-1:0]  RAD_MAX = {{(RW-W-1){1'b0}}, 1'b1, {W{1'b0}}};
  localparam logic signed [RW-1:0]  RAD_MIN = -RAD_MAX;
  localparam logic signed [OW-1:0]  OMAX = OW'(CMAXW);
  localparam logic signed [OW-1:0]  OMIN = OW'(CMINW);

  logic en;
  logic [TOL_WIDTH-1:0] tol_q;
  logic [XW-1:0] tolf;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign tolf          = XW'(tol_q) << F;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // input unpack
  logic signed [W-1:0] in_hit [3];
  logic signed [W-1:0] in_ctr [3];
  logic signed [W-1:0] in_ax  [3];
  logic [W-2:0] in_rad, in_hgt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_hit[i] = s_axis_tdata[i*W +: W];
      in_ctr[i] = s_axis_tdata[(3+i)*W +: W];
      in_ax[i]  = s_axis_tdata[(6+i)*W +: W];
    end
    in_rad = s_axis_tdata[9*W +: W-1];
    in_hgt = s_axis_tdata[10*W-1 +: W-1];
  end

  // valid chain of the front stages
  logic [9:1] vld_q;

  // stage 1: differences
  kind_e               kind1_q;
  logic signed [W-1:0] p1_q [3], c1_q [3], ax1_q [3];
  logic signed [CW-1:0] cp1_q [3];
  logic [W-2:0]        h1_q;
  logic [W:0]          rt1_q;

  // stage 2: products
  kind_e               kind2_q;
  logic signed [W-1:0] p2_q [3], c2_q [3], ax2_q [3];
  logic signed [CW-1:0] cp2_q [3];
  logic [PW-1:0]       sq2_q [3];
  logic signed [DW-1:0] dc2_q [3];
  logic [2*W-2:0]      oh2_q [3];
  logic                neg2_q [3];
  logic [PW-1:0]       rtsq2_q;
  logic [W-1:0]        axm1 [3];

  // stage 3: sums, cap offset
  kind_e               kind3_q;
  logic signed [W-1:0] p3_q [3], c3_q [3], ax3_q [3];
  logic signed [CW-1:0] cp3_q [3];
  logic [PW-1:0]       lsqc3_q, rtsq3_q;
  logic signed [DW-1:0] dotc3_q;
  logic signed [W+1:0] off3_q [3];
  logic signed [DW-1:0] dotc_d;
  logic [2*W-2:0]      offm [3], offc [3];

  // stage 4: top cap offsets, projection length, base cap test
  kind_e               kind4_q;
  logic signed [W-1:0] ax4_q [3];
  logic signed [CW-1:0] cp4_q [3], dp4_q [3];
  logic [PW-1:0]       rtsq4_q;
  logic signed [W+1:0] plen4_q;
  logic                capb4_q;
  logic signed [W+2:0] tsum [3];
  logic signed [W-1:0] tsat [3];
  logic [DW-1:0]       dca, dcs, dcc;

  // stage 5: products of top offsets and projection
  kind_e               kind5_q;
  logic signed [W-1:0] ax5_q [3];
  logic signed [CW-1:0] cp5_q [3];
  logic [PW-1:0]       rtsq5_q;
  logic                capb5_q;
  logic [PW-1:0]       sqd5_q [3];
  logic signed [DW-1:0] dd5_q [3];
  logic [2*W:0]        pm5_q [3];
  logic                prn5_q [3];
  logic [W-1:0]        axm4 [3];
  logic [W:0]          plm4;

  // stage 6: sums, projection components
  kind_e               kind6_q;
  logic signed [W-1:0] ax6_q [3];
  logic signed [CW-1:0] cp6_q [3];
  logic [PW-1:0]       rtsq6_q, lsqd6_q;
  logic                capb6_q;
  logic signed [DW-1:0] dotd6_q;
  logic signed [PRW-1:0] pr6_q [3];
  logic [2*W:0]        pmt [3];

  // stage 7: top cap test, radial vector, selection
  logic signed [VW-1:0] v7_q [3];
  logic signed [W-1:0]  fx7_q [3];
  logic                 use7_q, ok7_q;
  logic                 capt;
  logic [DW-1:0]        dda;
  logic signed [RW-1:0] radr [3];
  logic signed [VW-1:0] v7_d [3];
  logic signed [W-1:0]  fx7_d [3];

  // stages 8 and 9: squared length
  logic [PW-1:0]       vsq8_q [3];
  logic [W:0]          vm8_q [3];
  logic                vn8_q [3];
  logic signed [W-1:0] fx8_q [3];
  logic                use8_q, ok8_q;
  logic [PW-1:0]       s9_q;
  logic [W:0]          vm9_q [3];
  logic                vn9_q [3];
  logic signed [W-1:0] fx9_q [3];
  logic                use9_q, ok9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      axm1[i] = ax1_q[i][W-1] ? W'(-ax1_q[i]) : W'(ax1_q[i]);
    end
    dotc_d = dc2_q[0] + dc2_q[1] + dc2_q[2];
    for (int i = 0; i < 3; i++) begin
      offm[i] = oh2_q[i] >> F;
      offc[i] = (offm[i] > OFF_LIM) ? OFF_LIM : offm[i];
    end
    for (int i = 0; i < 3; i++) begin
      tsum[i] = (W+3)'(c3_q[i]) + (W+3)'(off3_q[i]);
      if (tsum[i] > TMAX) begin
        tsat[i] = CMAXW;
      end else if (tsum[i] < TMIN) begin
        tsat[i] = CMINW;
      end else begin
        tsat[i] = tsum[i][W-1:0];
      end
    end
    dca = dotc3_q[DW-1] ? DW'(-dotc3_q) : DW'(dotc3_q);
    dcs = dca >> F;
    dcc = (dcs > DOT_LIM) ? DOT_LIM : dcs;
    for (int i = 0; i < 3; i++) begin
      axm4[i] = ax4_q[i][W-1] ? W'(-ax4_q[i]) : W'(ax4_q[i]);
    end
    plm4 = plen4_q[W+1] ? (W+1)'(-plen4_q) : (W+1)'(plen4_q);
    for (int i = 0; i < 3; i++) begin
      pmt[i] = pm5_q[i] >> F;
    end
    dda  = dotd6_q[DW-1] ? DW'(-dotd6_q) : DW'(dotd6_q);
    capt = (lsqd6_q <= rtsq6_q) && (XW'(dda) < tolf);
    for (int i = 0; i < 3; i++) begin
      radr[i] = RW'(cp6_q[i]) - RW'(pr6_q[i]);
      if (radr[i] > RAD_MAX) begin
        radr[i] = RAD_MAX;
      end else if (radr[i] < RAD_MIN) begin
        radr[i] = RAD_MIN;
      end
      v7_d[i] = (kind6_q == KIND_SPHERE) ? VW'(cp6_q[i]) : radr[i][VW-1:0];
      case (kind6_q)
        KIND_PLANE: begin
          fx7_d[i] = ax6_q[i];
        end
        KIND_CYLINDER: begin
          if (capb6_q) begin
            fx7_d[i] = (ax6_q[i] == CMINW) ? CMAXW : -ax6_q[i];
          end else begin
            fx7_d[i] = ax6_q[i];
          end
        end
        default: begin
          fx7_d[i] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[8:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      kind1_q <= kind_e'(s_axis_tuser);
      for (int i = 0; i < 3; i++) begin
        p1_q[i]  <= in_hit[i];
        c1_q[i]  <= in_ctr[i];
        ax1_q[i] <= in_ax[i];
        cp1_q[i] <= CW'(in_hit[i]) - CW'(in_ctr[i]);
      end
      h1_q  <= in_hgt;
      rt1_q <= (W+1)'(in_rad) + (W+1)'(tol_q);
      // stage 2
      kind2_q <= kind1_q;
      for (int i = 0; i < 3; i++) begin
        p2_q[i]   <= p1_q[i];
        c2_q[i]   <= c1_q[i];
        ax2_q[i]  <= ax1_q[i];
        cp2_q[i]  <= cp1_q[i];
        sq2_q[i]  <= PW'(cp1_q[i]) * PW'(cp1_q[i]);
        dc2_q[i]  <= DW'(cp1_q[i]) * DW'(ax1_q[i]);
        oh2_q[i]  <= (2*W-1)'(axm1[i]) * (2*W-1)'(h1_q);
        neg2_q[i] <= ax1_q[i][W-1];
      end
      rtsq2_q <= PW'(rt1_q) * PW'(rt1_q);
      // stage 3
      kind3_q <= kind2_q;
      for (int i = 0; i < 3; i++) begin
        p3_q[i]  <= p2_q[i];
        c3_q[i]  <= c2_q[i];
        ax3_q[i] <= ax2_q[i];
        cp3_q[i] <= cp2_q[i];
        off3_q[i] <= neg2_q[i] ? -(W+2)'(offc[i]) : (W+2)'(offc[i]);
      end
      lsqc3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      rtsq3_q <= rtsq2_q;
      dotc3_q <= dotc_d;
      // stage 4
      kind4_q <= kind3_q;
      for (int i = 0; i < 3; i++) begin
        ax4_q[i] <= ax3_q[i];
        cp4_q[i] <= cp3_q[i];
        dp4_q[i] <= CW'(p3_q[i]) - CW'(tsat[i]);
      end
      rtsq4_q <= rtsq3_q;
      plen4_q <= dotc3_q[DW-1] ? -(W+2)'(dcc) : (W+2)'(dcc);
      capb4_q <= (lsqc3_q <= rtsq3_q) && (XW'(dca) < tolf);
      // stage 5
      kind5_q <= kind4_q;
      for (int i = 0; i < 3; i++) begin
        ax5_q[i]  <= ax4_q[i];
        cp5_q[i]  <= cp4_q[i];
        sqd5_q[i] <= PW'(dp4_q[i]) * PW'(dp4_q[i]);
        dd5_q[i]  <= DW'(dp4_q[i]) * DW'(ax4_q[i]);
        pm5_q[i]  <= (2*W+1)'(axm4[i]) * (2*W+1)'(plm4);
        prn5_q[i] <= ax4_q[i][W-1] ^ plen4_q[W+1];
      end
      rtsq5_q <= rtsq4_q;
      capb5_q <= capb4_q;
      // stage 6
      kind6_q <= kind5_q;
      for (int i = 0; i < 3; i++) begin
        ax6_q[i] <= ax5_q[i];
        cp6_q[i] <= cp5_q[i];
        pr6_q[i] <= prn5_q[i] ? -PRW'(pmt[i]) : PRW'(pmt[i]);
      end
      rtsq6_q <= rtsq5_q;
      capb6_q <= capb5_q;
      lsqd6_q <= sqd5_q[0] + sqd5_q[1] + sqd5_q[2];
      dotd6_q <= dd5_q[0] + dd5_q[1] + dd5_q[2];
      // stage 7
      for (int i = 0; i < 3; i++) begin
        v7_q[i]  <= v7_d[i];
        fx7_q[i] <= fx7_d[i];
      end
      use7_q <= (kind6_q == KIND_SPHERE) ||
                ((kind6_q == KIND_CYLINDER) && !capb6_q && !capt);
      ok7_q  <= (kind6_q != KIND_UNSUPPORTED);
      // stage 8
      for (int i = 0; i < 3; i++) begin
        vsq8_q[i] <= PW'(v7_q[i]) * PW'(v7_q[i]);
        vm8_q[i]  <= v7_q[i][VW-1] ? (W+1)'(-v7_q[i]) : (W+1)'(v7_q[i]);
        vn8_q[i]  <= v7_q[i][VW-1];
        fx8_q[i]  <= fx7_q[i];
      end
      use8_q <= use7_q;
      ok8_q  <= ok7_q;
      // stage 9
      s9_q <= vsq8_q[0] + vsq8_q[1] + vsq8_q[2];
      for (int i = 0; i < 3; i++) begin
        vm9_q[i] <= vm8_q[i];
        vn9_q[i] <= vn8_q[i];
        fx9_q[i] <= fx8_q[i];
      end
      use9_q <= use8_q;
      ok9_q  <= ok8_q;
    end
  end

  // square root pipeline, one root bit per stage
  logic [RMW-1:0]      sq_rem_q [N], sq_rem_d [N], sq_rin [N], sq_try [N];
  logic [N-1:0]        sq_root_q [N], sq_root_d [N], sq_rootin [N];
  logic [PW-1:0]       sq_x_q [N], sq_xin [N];
  logic [W:0]          sq_vm_q [N][3];
  logic                sq_vn_q [N][3];
  logic signed [W-1:0] sq_fx_q [N][3];
  logic                sq_use_q [N], sq_ok_q [N];
  logic [N-1:0]        sq_vld_q;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        sq_rin[k]    = '0;
        sq_rootin[k] = '0;
        sq_xin[k]    = s9_q;
      end else begin
        sq_rin[k]    = sq_rem_q[k-1];
        sq_rootin[k] = sq_root_q[k-1];
        sq_xin[k]    = sq_x_q[k-1];
      end
      sq_rem_d[k] = {sq_rin[k][RMW-3:0], sq_xin[k][2*(N-1-k) +: 2]};
      sq_try[k]   = RMW'({sq_rootin[k], 2'b01});
      if (sq_rem_d[k] >= sq_try[k]) begin
        sq_rem_d[k]  = sq_rem_d[k] - sq_try[k];
        sq_root_d[k] = {sq_rootin[k][N-2:0], 1'b1};
      end else begin
        sq_root_d[k] = {sq_rootin[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else if (en) begin
      for (int k = 0; k < N; k++) begin
        sq_vld_q[k] <= (k == 0) ? vld_q[9] : sq_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        sq_rem_q[k]  <= sq_rem_d[k];
        sq_root_q[k] <= sq_root_d[k];
        sq_x_q[k]    <= sq_xin[k];
        for (int i = 0; i < 3; i++) begin
          sq_vm_q[k][i] <= (k == 0) ? vm9_q[i] : sq_vm_q[k-1][i];
          sq_vn_q[k][i] <= (k == 0) ? vn9_q[i] : sq_vn_q[k-1][i];
          sq_fx_q[k][i] <= (k == 0) ? fx9_q[i] : sq_fx_q[k-1][i];
        end
        sq_use_q[k] <= (k == 0) ? use9_q : sq_use_q[k-1];
        sq_ok_q[k]  <= (k == 0) ? ok9_q : sq_ok_q[k-1];
      end
    end
  end

  // divider pipelines, one quotient bit per stage
  logic [W:0]          dv_rem_q [D][3], dv_rem_d [D][3], dv_rin [D][3];
  logic [W+1:0]        dv_t [D][3];
  logic [F:0]          dv_q_q [D][3], dv_q_d [D][3], dv_qin [D][3];
  logic [N-1:0]        dv_len_q [D], dv_lin [D];
  logic                dv_vn_q [D][3];
  logic signed [W-1:0] dv_fx_q [D][3];
  logic                dv_use_q [D], dv_ok_q [D];
  logic [D-1:0]        dv_vld_q;

  always_comb begin
    for (int j = 0; j < D; j++) begin
      dv_lin[j] = (j == 0) ? sq_root_q[N-1] : dv_len_q[j-1];
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          dv_rin[j][i] = sq_vm_q[N-1][i] >> 1;
          dv_qin[j][i] = '0;
          dv_t[j][i]   = {dv_rin[j][i], sq_vm_q[N-1][i][0]};
        end else begin
          dv_rin[j][i] = dv_rem_q[j-1][i];
          dv_qin[j][i] = dv_q_q[j-1][i];
          dv_t[j][i]   = {dv_rin[j][i], 1'b0};
        end
        if (dv_t[j][i] >= (W+2)'(dv_lin[j])) begin
          dv_rem_d[j][i] = (W+1)'(dv_t[j][i] - (W+2)'(dv_lin[j]));
          dv_q_d[j][i]   = {dv_qin[j][i][F-1:0], 1'b1};
        end else begin
          dv_rem_d[j][i] = dv_t[j][i][W:0];
          dv_q_d[j][i]   = {dv_qin[j][i][F-1:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (en) begin
      for (int j = 0; j < D; j++) begin
        dv_vld_q[j] <= (j == 0) ? sq_vld_q[N-1] : dv_vld_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < D; j++) begin
        dv_len_q[j] <= dv_lin[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j][i] <= dv_rem_d[j][i];
          dv_q_q[j][i]   <= dv_q_d[j][i];
          dv_vn_q[j][i]  <= (j == 0) ? sq_vn_q[N-1][i] : dv_vn_q[j-1][i];
          dv_fx_q[j][i]  <= (j == 0) ? sq_fx_q[N-1][i] : dv_fx_q[j-1][i];
        end
        dv_use_q[j] <= (j == 0) ? sq_use_q[N-1] : dv_use_q[j-1];
        dv_ok_q[j]  <= (j == 0) ? sq_ok_q[N-1] : dv_ok_q[j-1];
      end
    end
  end

  // output register
  logic signed [OW-1:0] oq [3];
  logic signed [W-1:0]  on_d [3];
  logic signed [W-1:0]  on_q [3];
  logic                 ook_q, ovld_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oq[i] = OW'(dv_q_q[D-1][i]);
      if (dv_vn_q[D-1][i]) begin
        oq[i] = -oq[i];
      end
      if (!dv_use_q[D-1]) begin
        on_d[i] = dv_fx_q[D-1][i];
      end else if (dv_len_q[D-1] == '0) begin
        on_d[i] = '0;
      end else if (oq[i] > OMAX) begin
        on_d[i] = CMAXW;
      end else if (oq[i] < OMIN) begin
        on_d[i] = CMINW;
      end else begin
        on_d[i] = oq[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (en) begin
      ovld_q <= dv_vld_q[D-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        on_q[i] <= on_d[i];
      end
      ook_q <= dv_ok_q[D-1];
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = OUT_DW'({on_q[2], on_q[1], on_q[0]});
  assign m_axis_tuser  = ook_q;

endmodule

`default_nettype wire
